FILE: src/lcs_pkg.sv
`default_nettype none

package lcs_pkg;

   // Capacity of each string and the derived widths.
   localparam int MAX_LEN   = 64;
   localparam int CNT_W     = $clog2(MAX_LEN + 1);
   localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int TBL_DEPTH = MAX_LEN * MAX_LEN;
   localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

   // Fixed field widths of the channels.
   localparam int OP_W  = 2;
   localparam int SYM_W = 8;
   localparam int LEN_W = 7;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE       = 2'd2;

   // Result of the shared cell unit.
   typedef struct packed {
      logic             match;
      logic             up_wins;
      logic [CNT_W-1:0] value;
   } cell_out_type;

   // Score table address of cell (r, c), both counted from one; the
   // border row and column are not stored.
   function automatic logic [TBL_AW-1:0] tbl_addr(input logic [CNT_W-1:0] r,
                                                  input logic [CNT_W-1:0] c);
      logic [TBL_AW-1:0] rr;
      logic [TBL_AW-1:0] cc;
      rr = TBL_AW'(r) - TBL_AW'(1);
      cc = TBL_AW'(c) - TBL_AW'(1);
      return rr * TBL_AW'(MAX_LEN) + cc;
   endfunction

endpackage

`default_nettype wire

FILE: src/lcs_ram.sv
`default_nettype none

// Simple dual-port memory: one write port, one read port with registered data.
module lcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; the read data holds while idle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/lcs_cell_unit.sv
`default_nettype none

// Shared compare unit: scores one table cell while filling, and decides the
// direction of one step while tracing back.
module lcs_cell_unit
   import lcs_pkg::*;
(
   input  wire logic [SYM_W-1:0] a_sym,
   input  wire logic [SYM_W-1:0] b_sym,
   input  wire logic [CNT_W-1:0] diag,
   input  wire logic [CNT_W-1:0] up,
   input  wire logic [CNT_W-1:0] left,
   output cell_out_type          result
);

   always_comb begin
      result.match   = (a_sym == b_sym);
      result.up_wins = (up > left);
      if (result.match) begin
         result.value = CNT_W'(diag + 1'b1);
      end else if (result.up_wins) begin
         result.value = up;
      end else begin
         result.value = left;
      end
   end

endmodule

`default_nettype wire

FILE: src/longest_common_subsequence_unit.sv
`default_nettype none

// Channel   Direction  Ports                                   Moves
// req_      in         operation, symbol                       one append or compute
// rsp_      out        out_symbol, total_length, is_empty,     one subsequence symbol
//                      truncated, last_of_run
//
// A compute fills the score table one cell a cycle,
// apart from a row symbol fetch before each row, then traces back via ST_TB_UP,
// ST_TB_LEFT and ST_TB_STEP per step and emits each result through ST_EMIT_READ and
// ST_EMIT_SEND; the single score table read port makes each step read up, then left.
// The block takes no new transaction until the last result has been taken.
// Reset clears both string counts and the dropped-symbol flag; no memory is cleared.
// A stalled result holds on the outputs until it is taken.
module longest_common_subsequence_unit
   import lcs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [OP_W-1:0]  req_operation,
   input  wire logic [SYM_W-1:0] req_symbol,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic      [SYM_W-1:0] rsp_out_symbol,
   output logic      [LEN_W-1:0] rsp_total_length,
   output logic                  rsp_is_empty,
   output logic                  rsp_truncated,
   output logic                  rsp_last_of_run
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL_ROW,
      ST_FILL_RUN,
      ST_FILL_DRAIN,
      ST_TB_UP,
      ST_TB_LEFT,
      ST_TB_STEP,
      ST_EMIT_READ,
      ST_EMIT_SEND
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] first_cnt_ff, first_cnt_in;
   logic [CNT_W-1:0] second_cnt_ff, second_cnt_in;
   logic             overflow_ff, overflow_in;
   logic             pvalid_ff, pvalid_in;
   logic [CNT_W-1:0] prow_ff, prow_in;
   logic [CNT_W-1:0] pcol_ff, pcol_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] diag_ff, diag_in;
   logic [CNT_W-1:0] up_ff, up_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] idx_ff, idx_in;

   // Memory ports.
   logic              a_wr_en, a_rd_en, b_wr_en, b_rd_en;
   logic [IDX_W-1:0]  a_wr_addr, a_rd_addr, b_wr_addr, b_rd_addr;
   logic [SYM_W-1:0]  a_rd_data, b_rd_data;
   logic              t_wr_en, t_rd_en;
   logic [TBL_AW-1:0] t_wr_addr, t_rd_addr;
   logic [CNT_W-1:0]  t_rd_data;
   logic              s_wr_en, s_rd_en;
   logic [IDX_W-1:0]  s_wr_addr, s_rd_addr;
   logic [SYM_W-1:0]  s_rd_data;

   // Shared unit.
   logic [CNT_W-1:0] unit_diag, unit_up, unit_left;
   logic [CNT_W-1:0] fill_up, tb_left;
   cell_out_type     unit_res;

   logic             req_fire, rsp_fire, is_last;

   lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_first_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_data (req_symbol),
      .rd_en   (a_rd_en),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_second_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (req_symbol),
      .rd_en   (b_rd_en),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   lcs_ram #(.WIDTH(CNT_W), .DEPTH(TBL_DEPTH)) u_score_ram (
      .clock   (clock),
      .wr_en   (t_wr_en),
      .wr_addr (t_wr_addr),
      .wr_data (unit_res.value),
      .rd_en   (t_rd_en),
      .rd_addr (t_rd_addr),
      .rd_data (t_rd_data)
   );

   lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_answer_ram (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (a_rd_data),
      .rd_en   (s_rd_en),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data)
   );

   // Cells on the border row or column score zero.
   assign fill_up = (prow_ff == CNT_W'(1)) ? '0 : t_rd_data;
   assign tb_left = (col_ff == CNT_W'(1)) ? '0 : t_rd_data;

   // The unit scores cells while filling and compares neighbours while tracing.
   always_comb begin
      if (state_ff == ST_TB_STEP) begin
         unit_diag = '0;
         unit_up   = up_ff;
         unit_left = tb_left;
      end else begin
         unit_diag = diag_ff;
         unit_up   = fill_up;
         unit_left = left_ff;
      end
   end

   lcs_cell_unit u_cell (
      .a_sym  (a_rd_data),
      .b_sym  (b_rd_data),
      .diag   (unit_diag),
      .up     (unit_up),
      .left   (unit_left),
      .result (unit_res)
   );

   // Handshake and result payload.
   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = (state_ff == ST_EMIT_SEND);
   assign req_fire         = req_valid && req_ready;
   assign rsp_fire         = rsp_valid && rsp_ready;
   assign rsp_is_empty     = (len_ff == '0);
   assign rsp_out_symbol   = rsp_is_empty ? '0 : s_rd_data;
   assign rsp_total_length = LEN_W'(len_ff);
   assign rsp_truncated    = overflow_ff;
   assign is_last          = rsp_is_empty || (CNT_W'(idx_ff + 1'b1) == len_ff);
   assign rsp_last_of_run  = is_last;

   // Sequencer: next state, memory controls and the fill pipeline.
   always_comb begin
      state_in      = state_ff;
      first_cnt_in  = first_cnt_ff;
      second_cnt_in = second_cnt_ff;
      overflow_in   = overflow_ff;
      pvalid_in     = 1'b0;
      prow_in       = prow_ff;
      pcol_in       = pcol_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      left_in       = left_ff;
      diag_in       = diag_ff;
      up_in         = up_ff;
      len_in        = len_ff;
      k_in          = k_ff;
      idx_in        = idx_ff;

      a_wr_en   = 1'b0;
      a_wr_addr = first_cnt_ff[IDX_W-1:0];
      a_rd_en   = 1'b0;
      a_rd_addr = IDX_W'(row_ff - 1'b1);
      b_wr_en   = 1'b0;
      b_wr_addr = second_cnt_ff[IDX_W-1:0];
      b_rd_en   = 1'b0;
      b_rd_addr = IDX_W'(col_ff - 1'b1);
      t_wr_en   = 1'b0;
      t_wr_addr = tbl_addr(prow_ff, pcol_ff);
      t_rd_en   = 1'b0;
      t_rd_addr = tbl_addr(CNT_W'(row_ff - 1'b1), col_ff);
      s_wr_en   = 1'b0;
      s_wr_addr = IDX_W'(k_ff - 1'b1);
      s_rd_en   = 1'b0;
      s_rd_addr = idx_ff[IDX_W-1:0];

      // Write back the cell that entered the pipeline last cycle.
      if (pvalid_ff) begin
         t_wr_en = 1'b1;
         left_in = unit_res.value;
         diag_in = fill_up;
         len_in  = unit_res.value;
         k_in    = unit_res.value;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_operation == OP_APPEND_FIRST) begin
                  if (first_cnt_ff < CNT_W'(MAX_LEN)) begin
                     a_wr_en      = 1'b1;
                     first_cnt_in = CNT_W'(first_cnt_ff + 1'b1);
                  end else begin
                     overflow_in = 1'b1;
                  end
               end else if (req_operation == OP_APPEND_SECOND) begin
                  if (second_cnt_ff < CNT_W'(MAX_LEN)) begin
                     b_wr_en       = 1'b1;
                     second_cnt_in = CNT_W'(second_cnt_ff + 1'b1);
                  end else begin
                     overflow_in = 1'b1;
                  end
               end else if (req_operation == OP_COMPUTE) begin
                  if (first_cnt_ff == '0 || second_cnt_ff == '0) begin
                     len_in   = '0;
                     idx_in   = '0;
                     state_in = ST_EMIT_SEND;
                  end else begin
                     row_in   = CNT_W'(1);
                     state_in = ST_FILL_ROW;
                  end
               end
            end
         end

         ST_FILL_ROW: begin
            // Fetch this row's symbol of the first string.
            a_rd_en  = 1'b1;
            col_in   = CNT_W'(1);
            left_in  = '0;
            diag_in  = '0;
            state_in = ST_FILL_RUN;
         end

         ST_FILL_RUN: begin
            // Issue one cell: the upper neighbour and the column symbol.
            b_rd_en   = 1'b1;
            t_rd_en   = 1'b1;
            pvalid_in = 1'b1;
            prow_in   = row_ff;
            pcol_in   = col_ff;
            if (col_ff == second_cnt_ff) begin
               if (row_ff == first_cnt_ff) begin
                  state_in = ST_FILL_DRAIN;
               end else begin
                  row_in   = CNT_W'(row_ff + 1'b1);
                  state_in = ST_FILL_ROW;
               end
            end else begin
               col_in = CNT_W'(col_ff + 1'b1);
            end
         end

         ST_FILL_DRAIN: begin
            // The corner cell is written now; the trace starts from it.
            state_in = ST_TB_UP;
         end

         ST_TB_UP: begin
            if (row_ff == '0 || col_ff == '0) begin
               idx_in = '0;
               if (len_ff == '0) begin
                  state_in = ST_EMIT_SEND;
               end else begin
                  state_in = ST_EMIT_READ;
               end
            end else begin
               a_rd_en  = 1'b1;
               b_rd_en  = 1'b1;
               t_rd_en  = 1'b1;
               state_in = ST_TB_LEFT;
            end
         end

         ST_TB_LEFT: begin
            up_in     = (row_ff == CNT_W'(1)) ? '0 : t_rd_data;
            t_rd_en   = 1'b1;
            t_rd_addr = tbl_addr(row_ff, CNT_W'(col_ff - 1'b1));
            state_in  = ST_TB_STEP;
         end

         ST_TB_STEP: begin
            // Match steps diagonally, otherwise up if strictly greater, else left.
            if (unit_res.match) begin
               if (k_ff != '0) begin
                  s_wr_en = 1'b1;
                  k_in    = CNT_W'(k_ff - 1'b1);
               end
               row_in = CNT_W'(row_ff - 1'b1);
               col_in = CNT_W'(col_ff - 1'b1);
            end else if (unit_res.up_wins) begin
               row_in = CNT_W'(row_ff - 1'b1);
            end else begin
               col_in = CNT_W'(col_ff - 1'b1);
            end
            state_in = ST_TB_UP;
         end

         ST_EMIT_READ: begin
            s_rd_en  = 1'b1;
            state_in = ST_EMIT_SEND;
         end

         ST_EMIT_SEND: begin
            if (rsp_fire) begin
               if (is_last) begin
                  first_cnt_in  = '0;
                  second_cnt_in = '0;
                  overflow_in   = 1'b0;
                  state_in      = ST_IDLE;
               end else begin
                  idx_in   = CNT_W'(idx_ff + 1'b1);
                  state_in = ST_EMIT_READ;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_cnt_ff  <= '0;
         second_cnt_ff <= '0;
         overflow_ff   <= 1'b0;
         pvalid_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_cnt_ff  <= first_cnt_in;
         second_cnt_ff <= second_cnt_in;
         overflow_ff   <= overflow_in;
         pvalid_ff     <= pvalid_in;
      end
      prow_ff <= prow_in;
      pcol_ff <= pcol_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      left_ff <= left_in;
      diag_ff <= diag_in;
      up_ff   <= up_in;
      len_ff  <= len_in;
      k_ff    <= k_in;
      idx_ff  <= idx_in;
   end

   // Checks.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("Transaction accepted while a result is pending.");

   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_of_run) |=> (req_ready && first_cnt_ff == '0))
      else $error("Block not cleared and ready after the final result.");

   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |->
         (rsp_out_symbol == '0 && rsp_total_length == '0 && rsp_last_of_run))
      else $error("Malformed empty-result marker.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (first_cnt_ff <= CNT_W'(MAX_LEN)) && (second_cnt_ff <= CNT_W'(MAX_LEN)))
      else $error("String count beyond capacity.");

endmodule

`default_nettype wire

FILE: sim/longest_common_subsequence_unit_tb.sv
`timescale 1ns / 1ps

module longest_common_subsequence_unit_tb;
   import lcs_pkg::*;

   // The fourth operation code has no name in the package; the block ignores it.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // One result transaction as the block should present it.
   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic [LEN_W-1:0] length;
      logic             empty;
      logic             truncated;
      logic             last;
   } lcs_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [OP_W-1:0]  req_operation = OP_UNUSED;
   logic [SYM_W-1:0] req_symbol = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [SYM_W-1:0] rsp_out_symbol;
   logic [LEN_W-1:0] rsp_total_length;
   logic             rsp_is_empty;
   logic             rsp_truncated;
   logic             rsp_last_of_run;

   // Shadow copy of the two strings and the dropped-symbol flag.
   logic [SYM_W-1:0] first_text [MAX_LEN];
   logic [SYM_W-1:0] second_text [MAX_LEN];
   int               first_len = 0;
   int               second_len = 0;
   bit               symbol_dropped = 1'b0;

   // Subsequence symbols still owed by the block, oldest first.
   lcs_result_type   owed_symbols [$];

   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               error_count = 0;
   int               items_sent = 0;
   int               computes_sent = 0;
   int               results_checked = 0;
   int               empty_runs = 0;
   int               dropped_runs = 0;
   int               longest_seen = 0;

   longest_common_subsequence_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_symbol       (req_symbol),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_symbol   (rsp_out_symbol),
      .rsp_total_length (rsp_total_length),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_truncated    (rsp_truncated),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // The timeout is several times the cost of every item being a full
   // compute with the longest result train under the slowest receiver.
   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   // Updates the shadow strings for an accepted transaction and, for a compute,
   // queues every symbol of the common subsequence that the trace recovers, or an empty marker.
   function automatic void predict_transaction(input logic [OP_W-1:0]  op,
                                               input logic [SYM_W-1:0] sym);
      int             score [0:MAX_LEN][0:MAX_LEN];
      logic [SYM_W-1:0] answer [MAX_LEN];
      int             r;
      int             c;
      int             len;
      int             k;
      lcs_result_type res;
      case (op)
         OP_APPEND_FIRST: begin
            if (first_len < MAX_LEN) begin
               first_text[first_len] = sym;
               first_len++;
            end else begin
               symbol_dropped = 1'b1;
            end
         end
         OP_APPEND_SECOND: begin
            if (second_len < MAX_LEN) begin
               second_text[second_len] = sym;
               second_len++;
            end else begin
               symbol_dropped = 1'b1;
            end
         end
         OP_COMPUTE: begin
            // Fill the score table with the usual recurrence.
            for (r = 0; r <= first_len; r++) begin
               for (c = 0; c <= second_len; c++) begin
                  if (r == 0 || c == 0)
                     score[r][c] = 0;
                  else if (first_text[r-1] == second_text[c-1])
                     score[r][c] = score[r-1][c-1] + 1;
                  else
                     score[r][c] = (score[r-1][c] > score[r][c-1]) ? score[r-1][c]
                                                                   : score[r][c-1];
               end
            end
            len = score[first_len][second_len];
            // Trace back from the corner; a tie steps left.
            k = len;
            r = first_len;
            c = second_len;
            while (r > 0 && c > 0) begin
               if (first_text[r-1] == second_text[c-1]) begin
                  k--;
                  answer[k] = first_text[r-1];
                  r--;
                  c--;
               end else if (score[r-1][c] > score[r][c-1]) begin
                  r--;
               end else begin
                  c--;
               end
            end
            if (len == 0) begin
               res = '{symbol: '0, length: '0, empty: 1'b1, truncated: symbol_dropped,
                       last: 1'b1};
               owed_symbols.push_back(res);
               empty_runs++;
            end else begin
               for (k = 0; k < len; k++) begin
                  res = '{symbol: answer[k], length: LEN_W'(len), empty: 1'b0,
                          truncated: symbol_dropped, last: (k == len - 1)};
                  owed_symbols.push_back(res);
               end
            end
            if (len > longest_seen)
               longest_seen = len;
            if (symbol_dropped)
               dropped_runs++;
            first_len = 0;
            second_len = 0;
            symbol_dropped = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // Offers one request transaction, with random idle cycles ahead of it, and
   // waits for it to be taken. Valid is left high so back-to-back items need no gap.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_symbol    <= sym;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_transaction(op, sym);
      if (op != OP_UNUSED)
         items_sent++;
      if (op == OP_COMPUTE)
         computes_sent++;
   endtask

   // The receiver's willingness is redrawn every cycle.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic void compare_field(input string name, input int expected,
                                         input int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, actual %0d", name, expected, actual);
         error_count++;
      end
   endfunction

   // Every result transaction is matched against the oldest owed symbol.
   always @(posedge clock) begin
      lcs_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_symbols.size() == 0) begin
            $error("result transaction with nothing expected: symbol %0d, length %0d",
                   rsp_out_symbol, rsp_total_length);
            error_count++;
         end else begin
            want = owed_symbols.pop_front();
            compare_field("out_symbol", int'(want.symbol), int'(rsp_out_symbol));
            compare_field("total_length", int'(want.length), int'(rsp_total_length));
            compare_field("is_empty", int'(want.empty), int'(rsp_is_empty));
            compare_field("truncated", int'(want.truncated), int'(rsp_truncated));
            compare_field("last_of_run", int'(want.last), int'(rsp_last_of_run));
            results_checked++;
         end
      end
   end

   function automatic int pick_length();
      int roll;
      roll = $urandom_range(15);
      if (roll < 11)
         return $urandom_range(6);
      else if (roll < 14)
         return $urandom_range(16, 7);
      else
         return $urandom_range(30, 17);
   endfunction

   // Empty strings, extreme symbols, the ignored code and the tie-break rule.
   task automatic test_directed_cases();
      // Both strings empty.
      send_item(OP_COMPUTE, 8'h00);
      // Only the first string loaded, then only the second.
      send_item(OP_APPEND_FIRST, 8'h00);
      send_item(OP_COMPUTE, 8'h00);
      send_item(OP_APPEND_SECOND, 8'h55);
      send_item(OP_COMPUTE, 8'hAA);
      // The unused code must leave the strings alone; the compute symbol is ignored.
      send_item(OP_UNUSED, 8'hFF);
      send_item(OP_APPEND_FIRST, 8'h00);
      send_item(OP_UNUSED, 8'h00);
      send_item(OP_APPEND_SECOND, 8'h00);
      send_item(OP_COMPUTE, 8'hFF);
      // Top symbol value matching, then a mismatch of the two extremes.
      send_item(OP_APPEND_FIRST, 8'hFF);
      send_item(OP_APPEND_SECOND, 8'hFF);
      send_item(OP_COMPUTE, 8'h00);
      send_item(OP_APPEND_FIRST, 8'h00);
      send_item(OP_APPEND_SECOND, 8'hFF);
      send_item(OP_COMPUTE, 8'h00);
      // Crossed pair: the upper and left cells tie, so the trace must step left.
      send_item(OP_APPEND_FIRST, 8'h41);
      send_item(OP_APPEND_FIRST, 8'h42);
      send_item(OP_APPEND_SECOND, 8'h42);
      send_item(OP_APPEND_SECOND, 8'h41);
      send_item(OP_COMPUTE, 8'h00);
   endtask

   // The first string filled to capacity and one past it, the second every fourth
   // symbol of the first, so the whole second string comes back with the dropped
   // flag set.
   task automatic test_full_capacity();
      logic [SYM_W-1:0] pattern [MAX_LEN + 1];
      int               i;
      for (i = 0; i <= MAX_LEN; i++) begin
         pattern[i] = 8'($urandom);
         send_item(OP_APPEND_FIRST, pattern[i]);
      end
      for (i = 0; i < MAX_LEN / 4; i++)
         send_item(OP_APPEND_SECOND, pattern[4 * i + 3]);
      send_item(OP_COMPUTE, 8'($urandom));
   endtask

   // Random string pairs, mostly short and over narrow alphabets so that matches
   // are common; now and then a pair is left uncomputed so the next one extends it.
   task automatic test_random_sequences(input int quota);
      int               sent;
      int               first_left;
      int               second_left;
      int               base;
      int               span;
      bit               narrow;
      logic [OP_W-1:0]  op;
      logic [SYM_W-1:0] sym;
      sent = 0;
      while (sent < quota) begin
         first_left  = pick_length();
         second_left = pick_length();
         narrow      = ($urandom_range(3) != 0);
         base        = $urandom_range(255);
         span        = $urandom_range(3, 1);
         while (first_left + second_left > 0) begin
            if ($urandom_range(15) == 0)
               send_item(OP_UNUSED, 8'($urandom));
            if (first_left > 0 && (second_left == 0 || $urandom_range(1) == 1)) begin
               op = OP_APPEND_FIRST;
               first_left--;
            end else begin
               op = OP_APPEND_SECOND;
               second_left--;
            end
            sym = narrow ? 8'(base ^ $urandom_range(span)) : 8'($urandom);
            send_item(op, sym);
            sent++;
         end
         if (sent >= quota || $urandom_range(7) != 0) begin
            send_item(OP_COMPUTE, 8'($urandom));
            sent++;
         end
      end
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      send_idle_pct  = sender_pct;
      recv_stall_pct = receiver_pct;
   endtask

   initial begin
      int guard;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Slow receiver.
      set_idling(24, 88);
      test_directed_cases();
      test_full_capacity();
      test_random_sequences(10);

      // Slow sender.
      set_idling(88, 24);
      test_random_sequences(10);

      // Both sides at full rate.
      set_idling(0, 0);
      test_random_sequences(10);

      // Drain the owed symbols, then watch a while for any stray result.
      req_valid <= 1'b0;
      while (owed_symbols.size() != 0)
         @(posedge clock);
      guard = 0;
      while (guard < 100) begin
         @(posedge clock);
         guard++;
      end

      $display("Sent %0d transactions including %0d computes; checked %0d result symbols.",
               items_sent, computes_sent, results_checked);
      $display("Empty runs %0d, runs with dropped symbols %0d, longest subsequence %0d.",
               empty_runs, dropped_runs, longest_seen);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
